// ===== rtl/erased_boundary_bisect_macros.svh =====
// assertion macros for the checker of the bisect block
`ifndef ERASED_BOUNDARY_BISECT_MACROS_SVH
`define ERASED_BOUNDARY_BISECT_MACROS_SVH

// same-cycle implication, quiet during reset
`define EBB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ebb check failed");

// next-cycle implication, quiet during reset
`define EBB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ebb check failed");

`endif

// ===== rtl/ebb_pkg.sv =====
`default_nettype none
package ebb_pkg;

    // default address width
    localparam int ADDR_BITS_DEF = 20;

    // round counter
    localparam int ROUNDS_W   = 5;
    localparam int ROUNDS_MAX = 31;

    // a span of this many addresses or fewer ends the search
    localparam int SPAN_STOP  = 2;

    // furthest probe after the midpoint
    localparam int PROBE_LAST = 3;

endpackage
`default_nettype wire

// ===== rtl/ebb_in_if.sv =====
`default_nettype none
interface ebb_in_if
    #(parameter int ADDR_BITS = ebb_pkg::ADDR_BITS_DEF);

    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] low_addr;
    logic [ADDR_BITS-1:0] high_addr;
    logic [ADDR_BITS-1:0] boundary;

    modport source (output valid, output low_addr, output high_addr, output boundary,
                    input ready);
    modport sink   (input valid, input low_addr, input high_addr, input boundary,
                    output ready);

endinterface
`default_nettype wire

// ===== rtl/ebb_out_if.sv =====
`default_nettype none
interface ebb_out_if
    #(parameter int ADDR_BITS = ebb_pkg::ADDR_BITS_DEF);

    logic                          valid;
    logic                          ready;
    logic [ADDR_BITS:0]            found_addr;
    logic [ebb_pkg::ROUNDS_W-1:0]  rounds;

    modport source (output valid, output found_addr, output rounds, input ready);
    modport sink   (input valid, input found_addr, input rounds, output ready);

endinterface
`default_nettype wire

// ===== rtl/erased_boundary_bisect.sv =====
`default_nettype none
// erased boundary bisect: finds the first erased address between low_addr and
// high_addr, where every address at or above boundary counts as erased. if
// low_addr is already erased the answer is low_addr with zero rounds, and a
// span of two addresses or fewer answers high_addr with zero rounds; otherwise
// each round probes the midpoint and the three addresses after it, either
// narrowing the upper bound or raising the lower one, and stopping early when
// one of the three follow-on probes hits. the answer is the final upper bound
// (up to high_addr + 2, hence the extra bit) and the number of rounds taken.
// pipeline: one setup stage and ADDR_BITS round stages, one round per stage,
// and a new request can be taken every cycle while the pipe is not stalled.
// the search never needs more than ADDR_BITS rounds, which sets the stage
// count. each stage holds its own valid bit and only stalls when the stage
// after it is full and stalled, so bubbles are squeezed out and a waiting
// answer does not block requests until the whole pipe is full.
module erased_boundary_bisect
    #(parameter int ADDR_BITS = ebb_pkg::ADDR_BITS_DEF)
    (
        input  logic      clk,
        input  logic      rst_n,
        ebb_in_if.sink    query,
        ebb_out_if.source answer
    );

    import ebb_pkg::*;

    localparam int AW = ADDR_BITS;
    localparam int HW = ADDR_BITS + 1;
    localparam int NR = ADDR_BITS;   // round stages
    localparam int NS = NR + 1;      // setup stage plus round stages

    // search state carried down the pipe
    // lo:    current lower bound, never erased while active
    // span:  hi - lo + 1 while active
    // reach: boundary - lo, so an address lo + x is erased when x >= reach
    // hi:    current upper bound, the answer once the search stops
    typedef struct packed {
        logic [AW-1:0]       lo;
        logic [HW-1:0]       span;
        logic [AW-1:0]       reach;
        logic [HW-1:0]       hi;
        logic                active;
        logic [ROUNDS_W-1:0] count;
    } stage_t;

    stage_t stage_reg   [NS];
    stage_t stage_next  [NS];
    logic   valid_reg   [NS];
    logic   stage_ready [NS];

    // setup stage: lower-bound check and initial span
    logic [AW+1:0] span_full;
    logic          lower_erased;
    logic          span_wide;

    assign span_full    = {2'b00, query.high_addr} - {2'b00, query.low_addr}
                          + (AW+2)'(1);
    assign lower_erased = query.low_addr >= query.boundary;
    // top bit is the sign: high below low gives a negative span
    assign span_wide    = !span_full[AW+1] && (span_full > (AW+2)'(SPAN_STOP));

    always_comb
    begin
        stage_next[0].lo     = query.low_addr;
        stage_next[0].span   = span_full[HW-1:0];
        stage_next[0].reach  = query.boundary - query.low_addr;
        stage_next[0].hi     = lower_erased ? {1'b0, query.low_addr}
                                            : {1'b0, query.high_addr};
        stage_next[0].active = !lower_erased && span_wide;
        stage_next[0].count  = '0;
    end

    // round stages: one midpoint probe group each
    for (genvar g = 1; g < NS; g++)
    begin : g_round
        logic [AW-1:0] half;
        logic [HW-1:0] half_w;
        logic [HW-1:0] reach_w;
        logic [HW-1:0] mid;
        logic [HW-1:0] span_up;
        logic          e0;
        logic          e1;
        logic          e2;
        logic          e3;

        assign half    = stage_reg[g-1].span[HW-1:1];
        assign half_w  = {1'b0, half};
        assign reach_w = {1'b0, stage_reg[g-1].reach};
        assign mid     = {1'b0, stage_reg[g-1].lo} + half_w;
        assign span_up = stage_reg[g-1].span - half_w;

        // midpoint and the addresses after it, checked against the boundary
        assign e0 = half_w >= reach_w;
        assign e1 = (half_w + HW'(1)) >= reach_w;
        assign e2 = (half_w + HW'(2)) >= reach_w;
        assign e3 = (half_w + HW'(PROBE_LAST)) >= reach_w;

        always_comb
        begin
            stage_next[g] = stage_reg[g-1];
            if (stage_reg[g-1].active)
            begin
                if (stage_reg[g-1].count != ROUNDS_W'(ROUNDS_MAX))
                begin
                    stage_next[g].count = stage_reg[g-1].count + ROUNDS_W'(1);
                end
                if (e0)
                begin
                    // erased midpoint becomes the upper bound, keep going
                    stage_next[g].hi     = mid;
                    stage_next[g].span   = half_w + HW'(1);
                    stage_next[g].active = half_w >= HW'(SPAN_STOP);
                end
                else if (e1)
                begin
                    stage_next[g].hi     = mid + HW'(1);
                    stage_next[g].active = 1'b0;
                end
                else if (e2)
                begin
                    stage_next[g].hi     = mid + HW'(2);
                    stage_next[g].active = 1'b0;
                end
                else if (e3)
                begin
                    stage_next[g].hi     = mid + HW'(PROBE_LAST);
                    stage_next[g].active = 1'b0;
                end
                else
                begin
                    // nothing erased yet: midpoint becomes the lower bound
                    stage_next[g].lo     = mid[AW-1:0];
                    stage_next[g].span   = span_up;
                    stage_next[g].reach  = stage_reg[g-1].reach - half;
                    stage_next[g].active = span_up > HW'(SPAN_STOP);
                end
            end
        end
    end

    // per-stage flow control: a stage moves on when it is empty or the next moves
    assign stage_ready[NS-1] = !valid_reg[NS-1] || answer.ready;
    for (genvar g = 0; g < NS - 1; g++)
    begin : g_ready
        assign stage_ready[g] = !valid_reg[g] || stage_ready[g+1];
    end

    for (genvar g = 0; g < NS; g++)
    begin : g_stage
        logic valid_in;

        if (g == 0)
        begin : g_first
            assign valid_in = query.valid;
        end
        else
        begin : g_rest
            assign valid_in = valid_reg[g-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (stage_ready[g])
            begin
                valid_reg[g] <= valid_in;
            end
        end

        // payload, no reset needed
        always_ff @(posedge clk)
        begin
            if (stage_ready[g])
            begin
                stage_reg[g] <= stage_next[g];
            end
        end
    end

    assign query.ready       = stage_ready[0];
    assign answer.valid      = valid_reg[NS-1];
    assign answer.found_addr = stage_reg[NS-1].hi;
    assign answer.rounds     = stage_reg[NS-1].count;

endmodule
`default_nettype wire

// ===== rtl/ebb_checker.sv =====
`default_nettype none
`include "erased_boundary_bisect_macros.svh"
module ebb_checker
    #(parameter int ADDR_BITS = ebb_pkg::ADDR_BITS_DEF)
    (
        input wire logic                         clk,
        input wire logic                         rst_n,
        input wire logic                         in_valid,
        input wire logic                         in_ready,
        input wire logic                         out_valid,
        input wire logic                         out_ready,
        input wire logic [ADDR_BITS:0]           found_addr,
        input wire logic [ebb_pkg::ROUNDS_W-1:0] rounds
    );

    import ebb_pkg::*;

    // a held answer stays up until taken
    `EBB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // a held answer keeps its payload
    `EBB_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready,
                     $stable(found_addr) && $stable(rounds))

    // requests only back up when the whole pipe is full and the answer stalls
    `EBB_ASSERT_SAME(a_backpressure, clk, rst_n, !in_ready, out_valid && !out_ready)

    // the search never needs more rounds than address bits
    `EBB_ASSERT_SAME(a_round_bound, clk, rst_n, out_valid,
                     rounds <= ROUNDS_W'(ADDR_BITS))

endmodule

bind erased_boundary_bisect ebb_checker #(.ADDR_BITS(ADDR_BITS)) u_ebb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (query.valid),
    .in_ready   (query.ready),
    .out_valid  (answer.valid),
    .out_ready  (answer.ready),
    .found_addr (answer.found_addr),
    .rounds     (answer.rounds)
);
`default_nettype wire
